/* sv/edf_pkg.sv */
// Shared types and constants for the EDF scheduler.
package edf_pkg;

    localparam int ID_W    = 8;
    localparam int SLOT_W  = 4;
    localparam int FIELD_W = 16;
    localparam int CNT_REG_W = 5;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic REG_TASK_COUNT = 1'b0;

    typedef struct packed {
        logic [ID_W-1:0]    task_id;
        logic [FIELD_W-1:0] arrival;
        logic [FIELD_W-1:0] burst;
        logic [FIELD_W-1:0] deadline;
        logic [FIELD_W-1:0] remaining;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_WRITE = 4'b1000
    } t_state;

    // true when candidate a beats incumbent b: earlier deadline, then earlier arrival,
    // then lower id
    function automatic logic better(t_entry a, t_entry b);
        logic res;
        if (a.deadline != b.deadline) begin
            res = (a.deadline < b.deadline);
        end else if (a.arrival != b.arrival) begin
            res = (a.arrival < b.arrival);
        end else begin
            res = (a.task_id < b.task_id);
        end
        return res;
    endfunction

endpackage

/* sv/edf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module edf_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/edf_preemptive_scheduler.sv */
// Top level of the preemptive earliest-deadline-first scheduler.
//
// Usage:
//   Command channel: raise start with the command fields while busy is low; the
//   word is taken at that clock edge. A load word (cmd = load) writes one slot of
//   the task table in that cycle, gives no result, and leaves busy low, so loads
//   can be issued back to back. A tick word (cmd = tick) scans the first
//   task_count slots, one table RAM read per slot, keeps the best ready slot,
//   writes its decremented remaining time back and advances time.
//   A tick keeps busy high through N RAM reads, N = min(task_count, MAX_TASKS),
//   then a drain step for the read pipeline and a write-back step.
//   With N = 0 only the write-back step remains and busy is high for one cycle.
//   The result word is on the o_ ports for exactly one cycle with o_valid high,
//   in the first cycle with busy low again; the next word may be taken then.
//   The receiver cannot stall: every result word is taken as it is shown.
//   Configuration: APB write of task_count at address 0, only while idle.
//   Reset: synchronous, active low; time goes to 0, task_count to 1 and every
//   slot reads as having no remaining work until loaded. No clearing pass.
module edf_preemptive_scheduler #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // command channel
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_cmd,
    input  logic [edf_pkg::SLOT_W-1:0]  i_slot,
    input  logic [edf_pkg::ID_W-1:0]    i_task_id,
    input  logic [edf_pkg::FIELD_W-1:0] i_arrival,
    input  logic [edf_pkg::FIELD_W-1:0] i_burst,
    input  logic [edf_pkg::FIELD_W-1:0] i_deadline,
    // result channel
    output logic                        o_valid,
    output logic [edf_pkg::FIELD_W-1:0] o_now,
    output logic                        o_idle,
    output logic [edf_pkg::SLOT_W-1:0]  o_run_slot,
    output logic [edf_pkg::ID_W-1:0]    o_run_id,
    output logic                        o_finished,
    output logic [edf_pkg::FIELD_W-1:0] o_finish_time,
    output logic [edf_pkg::FIELD_W-1:0] o_turnaround,
    output logic [edf_pkg::FIELD_W-1:0] o_waiting,
    output logic                        o_all_done,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    import edf_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    // width wide enough for both the time counter and the 16-bit time fields
    localparam int CW    = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [CNT_REG_W-1:0] r_task_count;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= CNT_REG_W'(1);
        end else if (cfg_wr && (paddr[2] == REG_TASK_COUNT)) begin
            r_task_count <= pwdata[CNT_REG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_TASK_COUNT) ? 32'(r_task_count) : 32'd0;

    // number of counted slots, clamped to the table depth
    logic [CNT_W-1:0] cnt_lim;
    assign cnt_lim = (32'(r_task_count) > MAX_TASKS) ? CNT_W'(MAX_TASKS)
                                                     : CNT_W'(r_task_count);

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_rd_idx;
    logic [IDX_W-1:0]       r_cmp_idx;
    logic                   r_cmp_vld;
    logic [CNT_W-1:0]       r_n;
    logic [CNT_W-1:0]       r_nz;
    logic                   r_found;
    logic [IDX_W-1:0]       r_best_slot;
    t_entry                 r_best;
    logic [MAX_TASKS-1:0]   r_valid;
    logic [TIME_BITS-1:0]   r_time, n_time;

    logic accept;
    logic is_load;
    logic load_ok;
    logic last_rd;

    assign busy    = (r_state != ST_IDLE);
    assign accept  = start && !busy;
    assign is_load = accept && (i_cmd == CMD_LOAD);
    // drop loads to slots beyond the table
    assign load_ok = is_load && (32'(i_slot) < MAX_TASKS);
    assign last_rd = (CNT_W'(r_rd_idx) == (r_n - CNT_W'(1)));

    // ------------------------------------------------------------------
    // task table RAM
    // ------------------------------------------------------------------
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    t_entry             ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             rd_entry;
    t_entry             load_entry;
    t_entry             wb_entry;

    assign load_entry = '{task_id:   i_task_id,
                          arrival:   i_arrival,
                          burst:     i_burst,
                          deadline:  i_deadline,
                          remaining: i_burst};

    logic [FIELD_W-1:0] dec_rem;
    assign dec_rem = r_best.remaining - FIELD_W'(1);

    always_comb begin
        wb_entry           = r_best;
        wb_entry.remaining = dec_rem;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_best_slot;
        ram_wdata = wb_entry;
        if (load_ok) begin
            ram_we    = 1'b1;
            ram_waddr = IDX_W'(i_slot);
            ram_wdata = load_entry;
        end else if ((r_state == ST_WRITE) && r_found) begin
            ram_we    = 1'b1;
        end
    end

    edf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = t_entry'(ram_rdata);

    // ------------------------------------------------------------------
    // compare stage: one slot per cycle against the running best
    // ------------------------------------------------------------------
    logic [FIELD_W-1:0] rd_rem;
    logic               rd_ready;
    logic               take;

    // a slot never loaded reads as having no remaining work
    assign rd_rem   = r_valid[r_cmp_idx] ? rd_entry.remaining : '0;
    assign rd_ready = r_cmp_vld && (rd_rem != '0)
                      && (CW'(rd_entry.arrival) <= CW'(r_time));
    // strict compare keeps the lower slot on a full tie
    assign take     = rd_ready && (!r_found || better(rd_entry, r_best));

    // ------------------------------------------------------------------
    // write-back stage: decrement, advance time, form result word
    // ------------------------------------------------------------------
    logic          fin_now;
    logic [CW-1:0] tat;
    logic [CW-1:0] wt;
    logic          all_done;

    assign n_time   = (&r_time) ? r_time : r_time + TIME_BITS'(1);
    assign fin_now  = r_found && (dec_rem == '0);
    assign tat      = CW'(n_time) - CW'(r_best.arrival);
    assign wt       = (tat >= CW'(r_best.burst)) ? tat - CW'(r_best.burst) : '0;
    // the finishing slot is the only nonzero one that drops to zero
    assign all_done = (r_nz == '0) || ((r_nz == CNT_W'(1)) && fin_now);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_cmd == CMD_TICK)) begin
                    n_state = (cnt_lim == '0) ? ST_WRITE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_rd) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_valid   <= '0;
            r_time    <= '0;
            r_rd_idx  <= '0;
            r_nz      <= '0;
        end else begin
            r_state <= n_state;

            // mark a slot loaded once it is written
            if (load_ok) begin
                r_valid[IDX_W'(i_slot)] <= 1'b1;
            end

            // advance the read pointer and the read pipeline
            r_cmp_vld <= (r_state == ST_SCAN);
            r_cmp_idx <= r_rd_idx;
            if (r_state == ST_IDLE) begin
                r_rd_idx <= '0;
            end else if (r_state == ST_SCAN) begin
                r_rd_idx <= r_rd_idx + IDX_W'(1);
            end

            if (accept && (i_cmd == CMD_TICK)) begin
                r_n     <= cnt_lim;
                r_found <= 1'b0;
                r_nz    <= '0;
            end else if (r_cmp_vld) begin
                if (rd_rem != '0) begin
                    r_nz <= r_nz + CNT_W'(1);
                end
                // a taken slot is loaded, so its stored remaining time is live
                if (take) begin
                    r_found     <= 1'b1;
                    r_best      <= rd_entry;
                    r_best_slot <= r_cmp_idx;
                end
            end

            if (r_state == ST_WRITE) begin
                r_time <= n_time;
            end
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic                r_strobe;
    logic [FIELD_W-1:0]  r_now;
    logic                r_idle;
    logic [SLOT_W-1:0]   r_run_slot;
    logic [ID_W-1:0]     r_run_id;
    logic                r_finished;
    logic [FIELD_W-1:0]  r_fin;
    logic [FIELD_W-1:0]  r_tat;
    logic [FIELD_W-1:0]  r_wt;
    logic                r_all_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == ST_WRITE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WRITE) begin
            r_now      <= FIELD_W'(n_time);
            r_idle     <= !r_found;
            r_run_slot <= r_found ? SLOT_W'(r_best_slot) : '0;
            r_run_id   <= r_found ? r_best.task_id : '0;
            r_finished <= fin_now;
            r_fin      <= fin_now ? FIELD_W'(n_time) : '0;
            r_tat      <= fin_now ? FIELD_W'(tat) : '0;
            r_wt       <= fin_now ? FIELD_W'(wt) : '0;
            r_all_done <= all_done;
        end
    end

    assign o_valid       = r_strobe;
    assign o_now         = r_now;
    assign o_idle        = r_idle;
    assign o_run_slot    = r_run_slot;
    assign o_run_id      = r_run_id;
    assign o_finished    = r_finished;
    assign o_finish_time = r_fin;
    assign o_turnaround  = r_tat;
    assign o_waiting     = r_wt;
    assign o_all_done    = r_all_done;

`ifndef SYNTHESIS
    a_strobe_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_WRITE))
        else $error("result word without write-back");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result word shown twice");

    a_finish_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_finished) |-> (!o_idle && o_all_done == 1'b0 || !o_idle))
        else $error("finished on an idle tick");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (CNT_W'(r_rd_idx) < r_n))
        else $error("scan read beyond counted slots");

    a_no_load_while_writeback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |-> !accept)
        else $error("command taken during write-back");
`endif

endmodule
